>>> hdl/ust_pkg.sv
// shared types, constants and helper functions for the utf-8 source tokenizer
// used by ust_scan and utf8_source_tokenizer_top; depends on nothing else

package ust_pkg;

	localparam int OFFSET_WIDTH_DEF = 24;
	localparam int LINE_WIDTH_DEF   = 24;
	localparam int VALUE_WIDTH_DEF  = 32;
	localparam int MAX_RES          = 4;
	localparam int TDATA_IN_W       = 8;
	localparam int TOK_BITS         = 118;
	localparam int TDATA_OUT_W      = 120;

	typedef enum logic [4:0] {
		KIND_IDENT     = 5'd0,
		KIND_KW_DHORI  = 5'd1,
		KIND_KW_JODI   = 5'd2,
		KIND_KW_NAHOLE = 5'd3,
		KIND_KW_SONG   = 5'd4,
		KIND_NUMBER    = 5'd5,
		KIND_GE        = 5'd6,
		KIND_LE        = 5'd7,
		KIND_EQEQ      = 5'd8,
		KIND_NE        = 5'd9,
		KIND_PLUS      = 5'd10,
		KIND_MINUS     = 5'd11,
		KIND_STAR      = 5'd12,
		KIND_SLASH     = 5'd13,
		KIND_ASSIGN    = 5'd14,
		KIND_GT        = 5'd15,
		KIND_LT        = 5'd16,
		KIND_SEMI      = 5'd17,
		KIND_LPAREN    = 5'd18,
		KIND_RPAREN    = 5'd19,
		KIND_LBRACE    = 5'd20,
		KIND_RBRACE    = 5'd21,
		KIND_UNKNOWN   = 5'd22,
		KIND_EOS       = 5'd23,
		KIND_DIGIT_ERR = 5'd24
	} kind_t;

	typedef enum logic [2:0] {
		MODE_IDLE   = 3'd0,
		MODE_IDENT  = 3'd1,
		MODE_NUMBER = 3'd2,
		MODE_OP     = 3'd3,
		MODE_DROP   = 3'd4
	} mode_t;

	typedef struct packed {
		logic [7:0]  tbyte;
		logic        ovf;
		logic [31:0] value;
		logic [23:0] line;
		logic [23:0] length;
		logic [23:0] start;
		kind_t       kind;
	} tok_t;

	localparam logic [7:0] LEAD_E0   = 8'hE0;
	localparam logic [7:0] MID_A7    = 8'hA7;
	localparam logic [7:0] DIGIT_LO  = 8'hA6;
	localparam logic [7:0] DIGIT_HI  = 8'hAF;

	localparam logic [4:0] KW_LEN [4] = '{5'd9, 5'd9, 5'd15, 5'd18};

	localparam logic [7:0] KW_TEXT [4][18] = '{
		'{8'hE0,8'hA6,8'hA7, 8'hE0,8'hA6,8'hB0, 8'hE0,8'hA6,8'hBF,
		  8'h00,8'h00,8'h00, 8'h00,8'h00,8'h00, 8'h00,8'h00,8'h00},
		'{8'hE0,8'hA6,8'hAF, 8'hE0,8'hA6,8'hA6, 8'hE0,8'hA6,8'hBF,
		  8'h00,8'h00,8'h00, 8'h00,8'h00,8'h00, 8'h00,8'h00,8'h00},
		'{8'hE0,8'hA6,8'hA8, 8'hE0,8'hA6,8'hBE, 8'hE0,8'hA6,8'hB9,
		  8'hE0,8'hA6,8'hB2, 8'hE0,8'hA7,8'h87, 8'h00,8'h00,8'h00},
		'{8'hE0,8'hA6,8'hB8, 8'hE0,8'hA6,8'h82, 8'hE0,8'hA6,8'h96,
		  8'hE0,8'hA7,8'h8D, 8'hE0,8'hA6,8'hAF, 8'hE0,8'hA6,8'hBE}
	};

	function automatic logic is_ident_byte(logic [7:0] b);
		logic [7:0] l;
		l = b | 8'h20;
		return (l >= 8'h61 && l <= 8'h7A) || (b >= 8'h30 && b <= 8'h39) || b[7];
	endfunction

	function automatic logic is_ascii_digit(logic [7:0] b);
		return b >= 8'h30 && b <= 8'h39;
	endfunction

	function automatic logic is_digit_tail(logic [7:0] b);
		return b >= DIGIT_LO && b <= DIGIT_HI;
	endfunction

	// keyword matcher step: {alive, index}
	function automatic logic [8:0] kw_step(logic [3:0] alive, logic [4:0] idx, logic [7:0] b);
		logic [3:0] a;
		logic [4:0] ni;
		a = alive;
		for (int k = 0; k < 4; k++) begin
			if (idx >= KW_LEN[k] || KW_TEXT[k][idx] != b)
				a[k] = 1'b0;
		end
		ni = (idx != 5'd31) ? idx + 5'd1 : idx;
		return {a, ni};
	endfunction

	function automatic kind_t kw_kind(logic [3:0] alive, logic [4:0] idx);
		kind_t k;
		k = KIND_IDENT;
		if (alive[0] && idx == KW_LEN[0]) k = KIND_KW_DHORI;
		if (alive[1] && idx == KW_LEN[1]) k = KIND_KW_JODI;
		if (alive[2] && idx == KW_LEN[2]) k = KIND_KW_NAHOLE;
		if (alive[3] && idx == KW_LEN[3]) k = KIND_KW_SONG;
		return k;
	endfunction

	function automatic kind_t op_kind(logic [7:0] c);
		kind_t k;
		case (c)
			8'h2B:   k = KIND_PLUS;
			8'h2D:   k = KIND_MINUS;
			8'h2A:   k = KIND_STAR;
			8'h2F:   k = KIND_SLASH;
			8'h3D:   k = KIND_ASSIGN;
			8'h3E:   k = KIND_GT;
			8'h3C:   k = KIND_LT;
			8'h3B:   k = KIND_SEMI;
			8'h28:   k = KIND_LPAREN;
			8'h29:   k = KIND_RPAREN;
			8'h7B:   k = KIND_LBRACE;
			8'h7D:   k = KIND_RBRACE;
			default: k = KIND_UNKNOWN;
		endcase
		return k;
	endfunction

	function automatic kind_t pair_kind(logic [7:0] h);
		kind_t k;
		case (h)
			8'h3E:   k = KIND_GE;
			8'h3C:   k = KIND_LE;
			8'h3D:   k = KIND_EQEQ;
			default: k = KIND_NE;
		endcase
		return k;
	endfunction

	function automatic logic is_pair_lead(logic [7:0] b);
		return b == 8'h3E || b == 8'h3C || b == 8'h3D || b == 8'h21;
	endfunction

	function automatic logic [23:0] sat24(logic [31:0] v);
		return (v[31:24] != 8'd0) ? 24'hFFFFFF : v[23:0];
	endfunction

endpackage

>>> hdl/ust_scan.sv
// scanner state and single-pass step logic: one source byte in, up to four tokens out
// depends on ust_pkg

module ust_scan #(
	parameter int OFFSET_WIDTH = ust_pkg::OFFSET_WIDTH_DEF,
	parameter int LINE_WIDTH   = ust_pkg::LINE_WIDTH_DEF,
	parameter int VALUE_WIDTH  = ust_pkg::VALUE_WIDTH_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               step,
	input  logic [7:0]         in_byte,
	input  logic               in_last,
	output ust_pkg::tok_t      res [ust_pkg::MAX_RES],
	output logic [2:0]         res_cnt
);

	localparam int OW = OFFSET_WIDTH;
	localparam int LW = LINE_WIDTH;
	localparam int VW = VALUE_WIDTH;

	logic [OW-1:0]          off_q, start_q;
	logic [LW-1:0]          line_q;
	ust_pkg::mode_t         mode_q;
	logic [7:0]             la_q;
	logic [1:0]             lc_q;
	logic [VW-1:0]          acc_q;
	logic                   sat_q;
	logic [3:0]             alive_q;
	logic [4:0]             idx_q;

	logic [OW-1:0]          off_d, start_d;
	logic [LW-1:0]          line_d;
	ust_pkg::mode_t         mode_d;
	logic [7:0]             la_d;
	logic [1:0]             lc_d;
	logic [VW-1:0]          acc_d;
	logic                   sat_d;
	logic [3:0]             alive_d;
	logic [4:0]             idx_d;

	function automatic ust_pkg::tok_t mk(ust_pkg::kind_t k, logic [OW-1:0] s,
			logic [OW-1:0] e, logic [LW-1:0] ln, logic [VW-1:0] a, logic sa,
			logic [7:0] by);
		ust_pkg::tok_t t;
		logic [OW-1:0] len;
		len      = e - s;
		t.kind   = k;
		t.start  = 24'(32'(s));
		t.length = ust_pkg::sat24(32'(len));
		t.line   = ust_pkg::sat24(32'(ln));
		t.value  = (k == ust_pkg::KIND_NUMBER) ? 32'(64'(a)) : 32'd0;
		t.ovf    = (k == ust_pkg::KIND_NUMBER) ? sa : 1'b0;
		t.tbyte  = by;
		return t;
	endfunction

	// value*10 + digit with saturation: {sat, acc}
	function automatic logic [VW:0] acc_step(logic [VW-1:0] a, logic sa, logic [3:0] d);
		logic [VW+3:0] p;
		p = ({4'd0, a} << 3) + ({4'd0, a} << 1) + (VW+4)'(d);
		if (sa || p[VW+3:VW] != 4'd0)
			return {1'b1, {VW{1'b1}}};
		return {1'b0, p[VW-1:0]};
	endfunction

	always_comb begin
		logic [OW-1:0] pos, fin;
		logic          fall, pfx;
		logic [2:0]    n;
		logic [8:0]    kw;
		logic [VW:0]   av;
		ust_pkg::tok_t t;

		pos     = off_q;
		start_d = start_q;
		line_d  = line_q;
		mode_d  = mode_q;
		la_d    = la_q;
		lc_d    = lc_q;
		acc_d   = acc_q;
		sat_d   = sat_q;
		alive_d = alive_q;
		idx_d   = idx_q;
		fall    = 1'b0;
		pfx     = 1'b0;
		n       = 3'd0;
		kw      = '0;
		av      = '0;
		t       = '0;
		for (int i = 0; i < ust_pkg::MAX_RES; i++)
			res[i] = '0;

		unique case (mode_q)
			ust_pkg::MODE_IDENT: begin
				if (ust_pkg::is_ident_byte(in_byte)) begin
					kw = ust_pkg::kw_step(alive_d, idx_d, in_byte);
					{alive_d, idx_d} = kw;
				end else begin
					res[0] = mk(ust_pkg::kw_kind(alive_d, idx_d), start_d, pos, line_d,
						acc_d, sat_d, 8'd0);
					n      = 3'd1;
					mode_d = ust_pkg::MODE_IDLE;
					fall   = 1'b1;
				end
			end
			ust_pkg::MODE_NUMBER: begin
				if (lc_q == 2'd0) begin
					if (in_byte == ust_pkg::LEAD_E0) begin
						la_d = in_byte;
						lc_d = 2'd1;
					end else begin
						res[0] = mk(ust_pkg::KIND_NUMBER, start_d, pos, line_d, acc_d, sat_d, 8'd0);
						n      = 3'd1;
						mode_d = ust_pkg::MODE_IDLE;
						acc_d  = '0;
						sat_d  = 1'b0;
						fall   = 1'b1;
					end
				end else if (lc_q == 2'd1 && in_byte == ust_pkg::MID_A7) begin
					lc_d = 2'd2;
				end else if (lc_q == 2'd2 && ust_pkg::is_digit_tail(in_byte)) begin
					av    = acc_step(acc_d, sat_d, 4'(in_byte - ust_pkg::DIGIT_LO));
					sat_d = av[VW];
					acc_d = av[VW-1:0];
					lc_d  = 2'd0;
				end else begin
					res[0] = mk(ust_pkg::KIND_NUMBER, start_d, pos - OW'(lc_q), line_d,
						acc_d, sat_d, 8'd0);
					n      = 3'd1;
					acc_d  = '0;
					sat_d  = 1'b0;
					pfx    = 1'b1;
				end
			end
			ust_pkg::MODE_OP: begin
				mode_d = ust_pkg::MODE_IDLE;
				if (in_byte == 8'h3D) begin
					res[0] = mk(ust_pkg::pair_kind(la_q), start_d, start_d + OW'(2), line_d,
						acc_d, sat_d, 8'd0);
					n      = 3'd1;
				end else begin
					res[0] = mk(ust_pkg::op_kind(la_q), start_d, start_d + OW'(1), line_d,
						acc_d, sat_d, la_q);
					n      = 3'd1;
					fall   = 1'b1;
				end
			end
			ust_pkg::MODE_DROP: begin
			end
			ust_pkg::MODE_IDLE: begin
				if (lc_q == 2'd1) begin
					if (in_byte == ust_pkg::MID_A7)
						lc_d = 2'd2;
					else
						pfx = 1'b1;
				end else if (lc_q == 2'd2) begin
					if (ust_pkg::is_digit_tail(in_byte)) begin
						mode_d  = ust_pkg::MODE_NUMBER;
						start_d = pos - OW'(2);
						acc_d   = VW'(in_byte - ust_pkg::DIGIT_LO);
						sat_d   = 1'b0;
						lc_d    = 2'd0;
					end else begin
						pfx = 1'b1;
					end
				end else begin
					fall = 1'b1;
				end
			end
			default: begin
			end
		endcase

		// broken digit prefix turns into the head of an identifier
		if (pfx) begin
			start_d = pos - OW'(lc_q);
			kw      = ust_pkg::kw_step(4'hF, 5'd0, ust_pkg::LEAD_E0);
			if (lc_q == 2'd2)
				kw = ust_pkg::kw_step(kw[8:5], kw[4:0], ust_pkg::MID_A7);
			{alive_d, idx_d} = kw;
			lc_d   = 2'd0;
			mode_d = ust_pkg::MODE_IDENT;
			if (ust_pkg::is_ident_byte(in_byte)) begin
				kw = ust_pkg::kw_step(alive_d, idx_d, in_byte);
				{alive_d, idx_d} = kw;
			end else begin
				res[n[1:0]] = mk(ust_pkg::kw_kind(alive_d, idx_d), start_d, pos, line_d,
					acc_d, sat_d, 8'd0);
				n      = n + 3'd1;
				mode_d = ust_pkg::MODE_IDLE;
				fall   = 1'b1;
			end
		end

		if (fall) begin
			if (in_byte == 8'h20 || in_byte == 8'h09 || in_byte == 8'h0D) begin
			end else if (in_byte == 8'h0A) begin
				if (line_d != {LW{1'b1}})
					line_d = line_d + LW'(1);
			end else if (in_byte == ust_pkg::LEAD_E0) begin
				la_d = in_byte;
				lc_d = 2'd1;
			end else if (ust_pkg::is_ascii_digit(in_byte)) begin
				res[n[1:0]] = mk(ust_pkg::KIND_DIGIT_ERR, pos, pos + OW'(1), line_d,
					acc_d, sat_d, in_byte);
				n      = n + 3'd1;
				mode_d = ust_pkg::MODE_DROP;
			end else if (ust_pkg::is_ident_byte(in_byte)) begin
				mode_d  = ust_pkg::MODE_IDENT;
				start_d = pos;
				kw      = ust_pkg::kw_step(4'hF, 5'd0, in_byte);
				{alive_d, idx_d} = kw;
			end else if (ust_pkg::is_pair_lead(in_byte)) begin
				la_d    = in_byte;
				start_d = pos;
				mode_d  = ust_pkg::MODE_OP;
			end else begin
				res[n[1:0]] = mk(ust_pkg::op_kind(in_byte), pos, pos + OW'(1), line_d,
					acc_d, sat_d, in_byte);
				n = n + 3'd1;
			end
		end

		off_d = (pos != {OW{1'b1}}) ? pos + OW'(1) : pos;
		fin   = off_d;

		// end of source: flush what is pending, then the end marker
		if (in_last) begin
			if (mode_d == ust_pkg::MODE_IDENT) begin
				t = mk(ust_pkg::kw_kind(alive_d, idx_d), start_d, fin, line_d, acc_d, sat_d, 8'd0);
				if (n < 3'd4) res[n[1:0]] = t;
				n = n + 3'd1;
			end else if (mode_d == ust_pkg::MODE_NUMBER) begin
				t = mk(ust_pkg::KIND_NUMBER, start_d, fin - OW'(lc_d), line_d, acc_d, sat_d, 8'd0);
				if (n < 3'd4) res[n[1:0]] = t;
				n = n + 3'd1;
			end else if (mode_d == ust_pkg::MODE_OP) begin
				t = mk(ust_pkg::op_kind(la_d), start_d, start_d + OW'(1), line_d,
					acc_d, sat_d, la_d);
				if (n < 3'd4) res[n[1:0]] = t;
				n = n + 3'd1;
			end
			if ((mode_d == ust_pkg::MODE_NUMBER || mode_d == ust_pkg::MODE_IDLE)
					&& lc_d != 2'd0) begin
				kw = ust_pkg::kw_step(4'hF, 5'd0, ust_pkg::LEAD_E0);
				if (lc_d == 2'd2)
					kw = ust_pkg::kw_step(kw[8:5], kw[4:0], ust_pkg::MID_A7);
				t = mk(ust_pkg::kw_kind(kw[8:5], kw[4:0]), fin - OW'(lc_d), fin, line_d,
					acc_d, sat_d, 8'd0);
				if (n < 3'd4) res[n[1:0]] = t;
				n = n + 3'd1;
			end
			t = mk(ust_pkg::KIND_EOS, fin, fin, line_d, acc_d, sat_d, 8'd0);
			if (n < 3'd4) res[n[1:0]] = t;
			n = n + 3'd1;

			off_d   = '0;
			line_d  = LW'(1);
			mode_d  = ust_pkg::MODE_IDLE;
			la_d    = '0;
			lc_d    = '0;
			start_d = '0;
			acc_d   = '0;
			sat_d   = 1'b0;
			alive_d = 4'hF;
			idx_d   = '0;
		end

		res_cnt = n;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			off_q   <= '0;
			line_q  <= LW'(1);
			mode_q  <= ust_pkg::MODE_IDLE;
			la_q    <= '0;
			lc_q    <= '0;
			start_q <= '0;
			acc_q   <= '0;
			sat_q   <= 1'b0;
			alive_q <= 4'hF;
			idx_q   <= '0;
		end else if (step) begin
			off_q   <= off_d;
			line_q  <= line_d;
			mode_q  <= mode_d;
			la_q    <= la_d;
			lc_q    <= lc_d;
			start_q <= start_d;
			acc_q   <= acc_d;
			sat_q   <= sat_d;
			alive_q <= alive_d;
			idx_q   <= idx_d;
		end
	end

endmodule

>>> hdl/utf8_source_tokenizer_top.sv
// top level of the utf-8 source tokenizer: input stage, scanner and token buffer
// depends on ust_pkg and ust_scan
//
// Usage:
// Source bytes arrive on the s_axis channel, one byte per beat, tdata[7:0] the
// byte and tlast marking the final byte of a source. Tokens leave on the
// m_axis channel, one token per beat; m_axis_tlast marks the last token caused
// by one source byte. Most bytes cause no token, a few cause one to four.
// A byte is registered in the input stage, scanned combinationally by ust_scan,
// and its tokens are registered into a four-entry token buffer. A byte is taken
// every cycle as long as the bytes in flight yield at most one token each and
// the receiver keeps tready high; a byte that yields several tokens holds the
// next token-yielding byte in the input stage until its last token is taken.
// A byte that yields no token is scanned even while the buffer still drains.
// When the receiver stalls, the buffer holds its tokens, and once the input
// stage is full, s_axis_tready drops.
// Reset clears the scanner to the start of a source (offset 0, line 1) and
// empties the input stage and the buffer. After the final byte, the scanner
// returns to that state by itself.

module utf8_source_tokenizer_top #(
	parameter int OFFSET_WIDTH = ust_pkg::OFFSET_WIDTH_DEF,
	parameter int LINE_WIDTH   = ust_pkg::LINE_WIDTH_DEF,
	parameter int VALUE_WIDTH  = ust_pkg::VALUE_WIDTH_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             s_axis_tvalid,
	output logic                             s_axis_tready,
	input  logic [ust_pkg::TDATA_IN_W-1:0]   s_axis_tdata,  // in_byte
	input  logic                             s_axis_tlast,  // in_last
	output logic                             m_axis_tvalid,
	input  logic                             m_axis_tready,
	// token_kind, token_start, token_length, line_number, number_value,
	// number_overflow, token_byte, zero fill
	output logic [ust_pkg::TDATA_OUT_W-1:0]  m_axis_tdata,
	output logic                             m_axis_tlast   // last_of_run
);

	logic                byte_vld_s1;
	logic [7:0]          byte_s1;
	logic                last_s1;
	ust_pkg::tok_t       res [ust_pkg::MAX_RES];
	logic [2:0]          res_cnt;
	ust_pkg::tok_t       buf_q [ust_pkg::MAX_RES];
	logic [2:0]          rem_q;
	logic [1:0]          rd_q;
	logic                buf_free, fire, take;
	ust_pkg::tok_t       head;

	ust_scan #(
		.OFFSET_WIDTH(OFFSET_WIDTH),
		.LINE_WIDTH  (LINE_WIDTH),
		.VALUE_WIDTH (VALUE_WIDTH)
	) u_scan (
		.clk     (clk),
		.arst_n  (arst_n),
		.step    (fire),
		.in_byte (byte_s1),
		.in_last (last_s1),
		.res     (res),
		.res_cnt (res_cnt)
	);

	assign take          = m_axis_tvalid && m_axis_tready;
	assign buf_free      = (rem_q == 3'd0) || (rem_q == 3'd1 && m_axis_tready);
	assign fire          = byte_vld_s1 && (res_cnt == 3'd0 || buf_free);
	assign s_axis_tready = !byte_vld_s1 || fire;

	assign head          = buf_q[rd_q];
	assign m_axis_tvalid = rem_q != 3'd0;
	assign m_axis_tlast  = rem_q == 3'd1;
	assign m_axis_tdata  = {{(ust_pkg::TDATA_OUT_W - ust_pkg::TOK_BITS){1'b0}}, head};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			byte_vld_s1 <= 1'b0;
		end else if (s_axis_tvalid && s_axis_tready) begin
			byte_vld_s1 <= 1'b1;
		end else if (fire) begin
			byte_vld_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tvalid && s_axis_tready) begin
			byte_s1 <= s_axis_tdata[7:0];
			last_s1 <= s_axis_tlast;
		end
	end

	// token buffer: loaded whole, drained one beat at a time
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rem_q <= '0;
			rd_q  <= '0;
		end else if (fire && res_cnt != 3'd0) begin
			rem_q <= res_cnt;
			rd_q  <= '0;
		end else if (take) begin
			rem_q <= rem_q - 3'd1;
			rd_q  <= rd_q + 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (fire && res_cnt != 3'd0) begin
			for (int i = 0; i < ust_pkg::MAX_RES; i++)
				buf_q[i] <= res[i];
		end
	end

endmodule

>>> tb/sv/utf8_source_tokenizer_top_test.sv
// testbench for utf8_source_tokenizer_top: directed byte table, then random sources
// tokens are predicted per accepted byte and checked beat by beat; needs ust_pkg and utf8_source_tokenizer_top
`timescale 1ns / 100ps

module utf8_source_tokenizer_top_test;

	localparam int NUM_RANDOM = 360;
	localparam int CYCLE_LIMIT = 400000;
	localparam int HOLD_CYCLES = 300;

	typedef struct {
		ust_pkg::tok_t tok;
		bit            last;
	} token_exp_t;

	typedef struct {
		logic [7:0]     b;
		bit             l;
		bit             typed;
		ust_pkg::kind_t kind;
		logic [7:0]     tbyte;
	} stim_row_t;

	logic clk;
	logic arst_n;
	logic s_axis_tvalid;
	logic s_axis_tready;
	logic [ust_pkg::TDATA_IN_W-1:0] s_axis_tdata;
	logic s_axis_tlast;
	logic m_axis_tvalid;
	logic m_axis_tready;
	logic [ust_pkg::TDATA_OUT_W-1:0] m_axis_tdata;
	logic m_axis_tlast;

	utf8_source_tokenizer_top i_dut (
		.clk(clk), .arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata), .s_axis_tlast(s_axis_tlast),
		.m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata), .m_axis_tlast(m_axis_tlast)
	);

	// scanner copy
	logic [23:0]    pos_cnt, line_cnt, tok_start;
	ust_pkg::mode_t mode;
	logic [7:0]     pend [2];
	int             pend_n;
	logic [63:0]    acc;
	bit             acc_sat;
	logic [3:0]     kw_live;
	logic [4:0]     kw_pos;

	token_exp_t token_q[$];
	logic [7:0] src_b[$];
	bit         src_l[$];
	int  errors = 0;
	int  tokens_seen = 0;
	int  bytes_sent = 0;
	int  cycles = 0;
	int  phase = 0;
	bit  hold_done = 0;
	int  hold_cnt = 0;

	function automatic bit word_byte(logic [7:0] b);
		logic [7:0] l;
		l = b | 8'h20;
		return (l >= "a" && l <= "z") || (b >= "0" && b <= "9") || b >= 8'd128;
	endfunction

	task automatic scan_reset();
		pos_cnt = 0; line_cnt = 1; mode = ust_pkg::MODE_IDLE; pend[0] = 0; pend[1] = 0;
		pend_n = 0; tok_start = 0; acc = 0; acc_sat = 0; kw_live = 4'hF; kw_pos = 0;
	endtask

	task automatic push_token(ust_pkg::kind_t k, logic [23:0] st, logic [23:0] en,
			logic [7:0] b);
		token_exp_t e;
		e.tok = '0;
		e.tok.kind = k;
		e.tok.start = st;
		e.tok.length = en - st;
		e.tok.line = line_cnt;
		e.tok.value = (k == ust_pkg::KIND_NUMBER) ? acc[31:0] : 32'd0;
		e.tok.ovf = (k == ust_pkg::KIND_NUMBER) ? acc_sat : 1'b0;
		e.tok.tbyte = b;
		e.last = 0;
		token_q.push_back(e);
	endtask

	task automatic kw_advance(logic [7:0] b);
		for (int k = 0; k < 4; k++)
			if (kw_pos >= ust_pkg::KW_LEN[k] || ust_pkg::KW_TEXT[k][kw_pos] != b)
				kw_live[k] = 1'b0;
		if (kw_pos != 5'd31)
			kw_pos++;
	endtask

	task automatic word_open(logic [23:0] st);
		mode = ust_pkg::MODE_IDENT; tok_start = st; kw_live = 4'hF; kw_pos = 0;
	endtask

	task automatic word_close(logic [23:0] en);
		ust_pkg::kind_t k;
		k = ust_pkg::KIND_IDENT;
		if (kw_live[0] && kw_pos == ust_pkg::KW_LEN[0]) k = ust_pkg::KIND_KW_DHORI;
		if (kw_live[1] && kw_pos == ust_pkg::KW_LEN[1]) k = ust_pkg::KIND_KW_JODI;
		if (kw_live[2] && kw_pos == ust_pkg::KW_LEN[2]) k = ust_pkg::KIND_KW_NAHOLE;
		if (kw_live[3] && kw_pos == ust_pkg::KW_LEN[3]) k = ust_pkg::KIND_KW_SONG;
		push_token(k, tok_start, en, 8'd0);
		mode = ust_pkg::MODE_IDLE;
	endtask

	// held prefix bytes become the head of a word
	task automatic pend_to_word(logic [23:0] p);
		int n;
		n = pend_n;
		word_open(p - 24'(n));
		for (int i = 0; i < n; i++)
			kw_advance(pend[i]);
		pend_n = 0;
	endtask

	task automatic number_close(logic [23:0] en);
		push_token(ust_pkg::KIND_NUMBER, tok_start, en, 8'd0);
		mode = ust_pkg::MODE_IDLE; acc = 0; acc_sat = 0;
	endtask

	task automatic add_digit(int d);
		if (acc_sat || acc > (64'hFFFF_FFFF - d) / 10) begin
			acc = 64'hFFFF_FFFF; acc_sat = 1;
		end else begin
			acc = acc * 10 + d;
		end
	endtask

	task automatic single_op(logic [7:0] c, logic [23:0] st);
		ust_pkg::kind_t k;
		case (c)
			"+": k = ust_pkg::KIND_PLUS;
			"-": k = ust_pkg::KIND_MINUS;
			"*": k = ust_pkg::KIND_STAR;
			"/": k = ust_pkg::KIND_SLASH;
			"=": k = ust_pkg::KIND_ASSIGN;
			">": k = ust_pkg::KIND_GT;
			"<": k = ust_pkg::KIND_LT;
			";": k = ust_pkg::KIND_SEMI;
			"(": k = ust_pkg::KIND_LPAREN;
			")": k = ust_pkg::KIND_RPAREN;
			"{": k = ust_pkg::KIND_LBRACE;
			"}": k = ust_pkg::KIND_RBRACE;
			default: k = ust_pkg::KIND_UNKNOWN;
		endcase
		push_token(k, st, st + 24'd1, c);
	endtask

	task automatic scan_byte(logic [7:0] b, logic [23:0] p);
		logic [7:0] h;
		ust_pkg::kind_t pk;
		while (1) begin
			if (mode == ust_pkg::MODE_IDENT) begin
				if (word_byte(b)) begin
					kw_advance(b);
					return;
				end
				word_close(p);
				continue;
			end
			if (mode == ust_pkg::MODE_NUMBER) begin
				if (pend_n == 0) begin
					if (b == ust_pkg::LEAD_E0) begin
						pend[0] = b; pend_n = 1;
						return;
					end
					number_close(p);
					continue;
				end
				if (pend_n == 1) begin
					if (b == ust_pkg::MID_A7) begin
						pend[1] = b; pend_n = 2;
						return;
					end
				end else if (b >= ust_pkg::DIGIT_LO && b <= ust_pkg::DIGIT_HI) begin
					add_digit(b - ust_pkg::DIGIT_LO);
					pend_n = 0;
					return;
				end
				number_close(p - 24'(pend_n));
				pend_to_word(p);
				continue;
			end
			if (mode == ust_pkg::MODE_OP) begin
				h = pend[0];
				mode = ust_pkg::MODE_IDLE;
				if (b == "=") begin
					pk = h == ">" ? ust_pkg::KIND_GE : h == "<" ? ust_pkg::KIND_LE :
						h == "=" ? ust_pkg::KIND_EQEQ : ust_pkg::KIND_NE;
					push_token(pk, tok_start, tok_start + 24'd2, 8'd0);
					return;
				end
				single_op(h, tok_start);
				continue;
			end
			if (mode == ust_pkg::MODE_DROP)
				return;
			if (pend_n == 1) begin
				if (b == ust_pkg::MID_A7) begin
					pend[1] = b; pend_n = 2;
					return;
				end
				pend_to_word(p);
				continue;
			end
			if (pend_n >= 2) begin
				if (b >= ust_pkg::DIGIT_LO && b <= ust_pkg::DIGIT_HI) begin
					mode = ust_pkg::MODE_NUMBER; tok_start = p - 24'd2; acc = 0; acc_sat = 0;
					add_digit(b - ust_pkg::DIGIT_LO);
					pend_n = 0;
					return;
				end
				pend_to_word(p);
				continue;
			end
			if (b == " " || b == 8'h09 || b == 8'h0D)
				return;
			if (b == 8'h0A) begin
				if (line_cnt != 24'hFFFFFF)
					line_cnt++;
				return;
			end
			if (b == ust_pkg::LEAD_E0) begin
				pend[0] = b; pend_n = 1;
				return;
			end
			if (b >= "0" && b <= "9") begin
				push_token(ust_pkg::KIND_DIGIT_ERR, p, p + 24'd1, b);
				mode = ust_pkg::MODE_DROP;
				return;
			end
			if (word_byte(b)) begin
				word_open(p);
				kw_advance(b);
				return;
			end
			if (b == ">" || b == "<" || b == "=" || b == "!") begin
				pend[0] = b; tok_start = p; mode = ust_pkg::MODE_OP;
				return;
			end
			single_op(b, p);
			return;
		end
	endtask

	task automatic predict_tokens(logic [7:0] b, bit l);
		int n0;
		logic [23:0] en;
		n0 = token_q.size();
		scan_byte(b, pos_cnt);
		if (pos_cnt != 24'hFFFFFF)
			pos_cnt++;
		if (l) begin
			en = pos_cnt;
			if (mode == ust_pkg::MODE_IDENT) begin
				word_close(en);
			end else if (mode == ust_pkg::MODE_NUMBER) begin
				if (pend_n == 0) begin
					number_close(en);
				end else begin
					number_close(en - 24'(pend_n));
					pend_to_word(en);
					word_close(en);
				end
			end else if (mode == ust_pkg::MODE_OP) begin
				single_op(pend[0], tok_start);
			end else if (mode == ust_pkg::MODE_IDLE && pend_n > 0) begin
				pend_to_word(en);
				word_close(en);
			end
			push_token(ust_pkg::KIND_EOS, en, en, 8'd0);
			scan_reset();
		end
		if (token_q.size() > n0)
			token_q[token_q.size() - 1].last = 1;
	endtask

	// random source text built from token-shaped pieces
	task automatic add_src(logic [7:0] b);
		src_b.push_back(b);
		src_l.push_back(0);
	endtask

	task automatic build_random();
		int k, n;
		while (src_b.size() < NUM_RANDOM) begin
			case ($urandom_range(11))
				0, 1: begin
					k = $urandom_range(3);
					n = ust_pkg::KW_LEN[k];
					if ($urandom_range(3) == 0) n = $urandom_range(1, n);
					for (int i = 0; i < n; i++) add_src(ust_pkg::KW_TEXT[k][i]);
					if ($urandom_range(4) == 0) add_src("a");
				end
				2, 3: begin
					n = ($urandom_range(4) == 0) ? $urandom_range(10, 14) : $urandom_range(1, 4);
					for (int i = 0; i < n; i++) begin
						add_src(ust_pkg::LEAD_E0); add_src(ust_pkg::MID_A7);
						add_src(ust_pkg::DIGIT_LO + 8'($urandom_range(9)));
					end
					if ($urandom_range(3) == 0) add_src(ust_pkg::LEAD_E0);
				end
				4: begin
					n = $urandom_range(1, 5);
					add_src(8'("a" + $urandom_range(25)));
					for (int i = 1; i < n; i++)
						add_src($urandom_range(1) ? 8'("A" + $urandom_range(25)) :
							8'(128 + $urandom_range(127)));
				end
				5, 6: begin
					case ($urandom_range(16))
						0: add_src("+"); 1: add_src("-"); 2: add_src("*"); 3: add_src("/");
						4: add_src("="); 5: add_src(">"); 6: add_src("<"); 7: add_src(";");
						8: add_src("("); 9: add_src(")"); 10: add_src("{"); 11: add_src("}");
						default: begin
							add_src($urandom_range(1) ? ">" : ($urandom_range(1) ? "<" : "!"));
							if ($urandom_range(1)) add_src("=");
						end
					endcase
				end
				7: add_src($urandom_range(1) ? " " : ($urandom_range(1) ? 8'h0A : 8'h09));
				8: begin
					add_src(ust_pkg::LEAD_E0);
					if ($urandom_range(1)) add_src(ust_pkg::MID_A7);
					add_src(8'($urandom_range(255)));
				end
				9: add_src(8'($urandom_range(255)));
				10: if ($urandom_range(5) == 0) add_src(8'("0" + $urandom_range(9)));
				default: add_src($urandom_range(1) ? 8'h0D : 8'h0A);
			endcase
			if ($urandom_range(29) == 0) src_l[src_l.size() - 1] = 1;
		end
		src_l[src_l.size() - 1] = 1;
	endtask

	initial begin
		clk = 0;
		forever #4 clk = ~clk;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("Verification failed");
			$finish;
		end
	end

	// receiver: random stalls per phase, plus one long hold-off
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_axis_tready <= 0;
		end else if (hold_cnt > 0) begin
			hold_cnt <= hold_cnt - 1;
			m_axis_tready <= 0;
		end else if (!hold_done && bytes_sent >= 150) begin
			hold_done <= 1;
			hold_cnt <= HOLD_CYCLES;
			m_axis_tready <= 0;
		end else begin
			m_axis_tready <= (phase == 2) ? ($urandom_range(99) >= 79) :
				(phase == 3) ? ($urandom_range(99) >= 21) : 1'b1;
		end
	end

	always @(posedge clk) begin
		ust_pkg::tok_t got;
		token_exp_t e;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			got = ust_pkg::tok_t'(m_axis_tdata[ust_pkg::TOK_BITS-1:0]);
			tokens_seen++;
			if (token_q.size() == 0) begin
				$error("token with none pending: kind %0d", got.kind);
				errors++;
			end else begin
				e = token_q.pop_front();
				if (got.kind !== e.tok.kind) begin
					$error("token_kind exp %0d got %0d", e.tok.kind, got.kind); errors++;
				end
				if (got.start !== e.tok.start) begin
					$error("token_start exp %0d got %0d", e.tok.start, got.start); errors++;
				end
				if (got.length !== e.tok.length) begin
					$error("token_length exp %0d got %0d", e.tok.length, got.length); errors++;
				end
				if (got.line !== e.tok.line) begin
					$error("line_number exp %0d got %0d", e.tok.line, got.line); errors++;
				end
				if (got.value !== e.tok.value) begin
					$error("number_value exp %0d got %0d", e.tok.value, got.value); errors++;
				end
				if (got.ovf !== e.tok.ovf) begin
					$error("number_overflow exp %0d got %0d", e.tok.ovf, got.ovf); errors++;
				end
				if (got.tbyte !== e.tok.tbyte) begin
					$error("token_byte exp %0h got %0h", e.tok.tbyte, got.tbyte); errors++;
				end
				if (m_axis_tlast !== e.last) begin
					$error("last_of_run exp %0d got %0d", e.last, m_axis_tlast); errors++;
				end
			end
		end
	end

	initial begin
		stim_row_t rows[$];
		int n0, gap;
		s_axis_tvalid = 0;
		s_axis_tdata = 0;
		s_axis_tlast = 0;
		arst_n = 0;
		scan_reset();
		// digit error then dropped bytes, operators, lone bang, number, broken prefix
		rows = '{
			'{"3", 0, 1, ust_pkg::KIND_DIGIT_ERR, "3"}, '{"q", 0, 0, ust_pkg::KIND_IDENT, 0},
			'{8'h0A, 0, 0, ust_pkg::KIND_IDENT, 0}, '{"z", 1, 1, ust_pkg::KIND_EOS, 8'h00},
			'{">", 0, 0, ust_pkg::KIND_IDENT, 0}, '{"=", 0, 1, ust_pkg::KIND_GE, 8'h00},
			'{"!", 0, 0, ust_pkg::KIND_IDENT, 0}, '{"a", 0, 1, ust_pkg::KIND_UNKNOWN, "!"},
			'{8'h00, 0, 0, ust_pkg::KIND_IDENT, 0}, '{8'hE0, 0, 0, ust_pkg::KIND_IDENT, 0},
			'{8'hA7, 0, 0, ust_pkg::KIND_IDENT, 0}, '{8'hAF, 0, 0, ust_pkg::KIND_IDENT, 0},
			'{8'hE0, 0, 0, ust_pkg::KIND_IDENT, 0}, '{8'hA7, 0, 0, ust_pkg::KIND_IDENT, 0},
			'{8'hA6, 0, 0, ust_pkg::KIND_IDENT, 0}, '{";", 0, 0, ust_pkg::KIND_IDENT, 0},
			'{8'hFF, 0, 0, ust_pkg::KIND_IDENT, 0}, '{8'h0A, 0, 0, ust_pkg::KIND_IDENT, 0},
			'{"}", 0, 0, ust_pkg::KIND_IDENT, 0}, '{8'h09, 0, 0, ust_pkg::KIND_IDENT, 0},
			'{8'hE0, 0, 0, ust_pkg::KIND_IDENT, 0}, '{8'hA7, 0, 0, ust_pkg::KIND_IDENT, 0},
			'{"x", 1, 0, ust_pkg::KIND_IDENT, 0}
		};
		build_random();
		repeat (2) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);
		for (int i = 0; i < rows.size() + src_b.size(); i++) begin
			if (i >= rows.size())
				phase = ((i - rows.size()) * 4) / src_b.size();
			gap = (phase == 1) ? 79 : (phase == 3) ? 21 : 0;
			while ($urandom_range(99) < gap) begin
				s_axis_tvalid <= 0;
				@(posedge clk);
			end
			s_axis_tvalid <= 1;
			s_axis_tdata <= (i < rows.size()) ? rows[i].b : src_b[i - rows.size()];
			s_axis_tlast <= (i < rows.size()) ? rows[i].l : src_l[i - rows.size()];
			do @(posedge clk); while (!s_axis_tready);
			n0 = token_q.size();
			predict_tokens(s_axis_tdata, s_axis_tlast);
			if (i < rows.size() && rows[i].typed) begin
				token_q[n0].tok.kind = rows[i].kind;
				token_q[n0].tok.tbyte = rows[i].tbyte;
			end
			bytes_sent++;
		end
		s_axis_tvalid <= 0;
		phase = 0;
		while (token_q.size() > 0)
			@(posedge clk);
		repeat (20) @(posedge clk);
		$display("%0d source bytes sent, %0d tokens checked, over four idling phases",
			bytes_sent, tokens_seen);
		$display("and one long receiver hold-off; %0d mismatches", errors);
		if (errors == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule
